// ----- sv/sor_pkg.sv -----
`default_nettype none

package sor_pkg;

	localparam int RING_DEPTH = 16;
	localparam int IDX_W      = $clog2(RING_DEPTH);
	localparam int CNT_W      = $clog2(RING_DEPTH + 1);

	localparam int REQ_W      = 2;
	localparam int KIND_W     = 3;
	localparam int VER_W      = 63;
	localparam int SEQ_W      = 63;
	localparam int MAXC_W     = 7;
	localparam int STAT_W     = 2;
	localparam int PCT_W      = 7;
	localparam int CAP_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 5;
	localparam int ENT_W      = KIND_W + VER_W;

	// fill * 100 as the dividend of the usage divider
	localparam int PCT_SCALE  = 100;
	localparam int DIVD_W     = $clog2(RING_DEPTH * PCT_SCALE + 1);

	typedef enum logic [REQ_W-1:0] {
		REQ_PUSH   = 2'd0,
		REQ_LOOKUP = 2'd1,
		REQ_RANGE  = 2'd2,
		REQ_STATS  = 2'd3
	} req_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK       = 2'd0,
		ST_REJECTED = 2'd1,
		ST_NOTFOUND = 2'd2,
		ST_EMPTY    = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CAPACITY = 1'd0,
		CFG_ENABLE   = 1'd1
	} cfg_reg_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_LOOK,
		S_STAT,
		S_SCAN,
		S_PICK,
		S_EMIT
	} state_t;

	typedef struct packed {
		logic             done;
		logic [PCT_W-1:0] quotient;
	} div_res_t;

endpackage

`default_nettype wire

// ----- sv/sor_div.sv -----
`default_nettype none

// restoring divider, one quotient bit per cycle
module sor_div
	import sor_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [CNT_W-1:0]  divisor,
	output div_res_t               res
);

	localparam int ITER_W = $clog2(DIVD_W + 1);

	logic [DIVD_W-1:0] num_q;
	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  dvs_q;
	logic [ITER_W-1:0] iter_q;
	logic              done_q;

	logic [CNT_W:0]    trial;
	logic              take;
	logic [CNT_W:0]    diff;

	always_comb begin
		trial = {rem_q, num_q[DIVD_W-1]};
		take  = trial >= {1'b0, dvs_q};
		diff  = trial - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iter_q <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			iter_q <= ITER_W'(DIVD_W);
			done_q <= 1'b0;
		end else if (iter_q != '0) begin
			iter_q <= iter_q - ITER_W'(1);
			if (iter_q == ITER_W'(1)) begin
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (iter_q != '0) begin
			num_q <= {num_q[DIVD_W-2:0], take};
			rem_q <= take ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
		end
	end

	assign res.done     = done_q;
	assign res.quotient = num_q[PCT_W-1:0];

endmodule

`default_nettype wire

// ----- sv/sequenced_overwrite_event_ring_core.sv -----
// Push: result registered at the accepting edge. Lookup: ring read, then
// result. Statistics: result from the serial fill*100/capacity divider
// (11 quotient bits). Range read: scan over the stored entries, then per
// emitted entry a ring read port step and an output register step; an
// empty range answers right after the scan. One request in flight at a
// time. Async active-low reset clears control state; ring contents are
// undefined until written, capacity resets to 16.
`default_nettype none

module sequenced_overwrite_event_ring_core
	import sor_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	// request channel
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [KIND_W-1:0]     event_kind,
	input  wire logic [VER_W-1:0]      obj_version,
	input  wire logic [SEQ_W-1:0]      seq_query,
	input  wire logic [MAXC_W-1:0]     max_count,

	// result channel
	output logic                       out_valid,
	input  wire logic                  out_stall,
	output logic [STAT_W-1:0]          status,
	output logic [KIND_W-1:0]          out_kind,
	output logic [VER_W-1:0]           out_version,
	output logic [SEQ_W-1:0]           out_sequence,
	output logic                       last_of_run,
	output logic [SEQ_W-1:0]           total_pushed,
	output logic [PCT_W-1:0]           usage_percent,

	// configuration writes
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	// slot + off, folded back into 0..cap-1 (off < cap, slot < cap)
	function automatic logic [IDX_W-1:0] ring_wrap(input logic [IDX_W-1:0] slot,
		input logic [CNT_W-1:0] off, input logic [CNT_W-1:0] cap);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(slot) + (CNT_W+1)'(off);
		if (sum >= {1'b0, cap}) begin
			sum = sum - {1'b0, cap};
		end
		return sum[IDX_W-1:0];
	endfunction

	// ---------------------------------------------------------------
	// State
	// ---------------------------------------------------------------
	state_t            state_q, state_d;

	logic [CAP_W-1:0]  cap_q;
	logic              en_q;
	logic [CNT_W-1:0]  fill_q;
	logic [IDX_W-1:0]  oldest_q;
	logic [IDX_W-1:0]  next_q;
	logic [SEQ_W-1:0]  total_q;
	// sequence of the oldest stored entry, kept as total - fill
	logic [SEQ_W-1:0]  base_q;

	// per-request working registers
	logic [SEQ_W-1:0]      query_q;
	logic [MAXC_W-1:0]     maxc_q;
	logic                  hit_q;
	logic [CNT_W-1:0]      scan_q;
	logic [SEQ_W-1:0]      run_seq_q;
	logic [RING_DEPTH-1:0] mask_q;
	logic [CNT_W-1:0]      emit_cnt_q;
	logic [SEQ_W-1:0]      emit_seq_q;
	logic                  emit_last_q;

	// output register
	logic              out_valid_q;
	status_t           status_q;
	logic [KIND_W-1:0] kind_q;
	logic [VER_W-1:0]  version_q;
	logic [SEQ_W-1:0]  sequence_q;
	logic              last_q;
	logic [SEQ_W-1:0]  total_out_q;
	logic [PCT_W-1:0]  usage_q;

	// ring memory: {kind, version} per slot, registered read
	logic [ENT_W-1:0]  ring_mem [RING_DEPTH];
	logic [ENT_W-1:0]  rd_s1;

	// ---------------------------------------------------------------
	// Derived values
	// ---------------------------------------------------------------
	logic [CNT_W-1:0]  cap_eff;
	logic              out_free;
	logic              accept;
	logic [SEQ_W-1:0]  lk_diff;
	logic              lk_hit;
	logic              scan_done;
	logic              range_empty;
	logic [IDX_W-1:0]  pick_j;
	logic              pick_last;
	div_res_t          div_res;

	always_comb begin
		if (cap_q == '0) begin
			cap_eff = CNT_W'(1);
		end else if (int'(cap_q) > RING_DEPTH) begin
			cap_eff = CNT_W'(RING_DEPTH);
		end else begin
			cap_eff = CNT_W'(cap_q);
		end
	end

	// output register frees up when empty or being taken this cycle
	assign out_free = !out_valid_q || !out_stall;
	assign in_stall = (state_q != S_IDLE) || !out_free;
	assign accept   = in_valid && !in_stall;

	// stored sequences are consecutive from base, so a lookup is a subtract
	assign lk_diff = seq_query - base_q;
	assign lk_hit  = lk_diff < SEQ_W'(fill_q);

	assign scan_done   = scan_q == fill_q;
	assign range_empty = (mask_q == '0) || (maxc_q == '0);

	// lowest qualifying position still to emit
	always_comb begin
		pick_j = '0;
		for (int k = RING_DEPTH - 1; k >= 0; k--) begin
			if (mask_q[k]) begin
				pick_j = IDX_W'(k);
			end
		end
	end

	// last of the run: count limit reached or nothing left in the mask
	always_comb begin
		logic [RING_DEPTH-1:0] rest;
		rest = mask_q;
		rest[pick_j] = 1'b0;
		pick_last = (MAXC_W'(emit_cnt_q) + MAXC_W'(1) == maxc_q) || (rest == '0);
	end

	// ---------------------------------------------------------------
	// Sequencer: next state
	// ---------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_PUSH:   state_d = S_IDLE;
						REQ_LOOKUP: state_d = S_LOOK;
						REQ_RANGE:  state_d = S_SCAN;
						REQ_STATS:  state_d = S_STAT;
					endcase
				end
			end
			S_LOOK: begin
				if (out_free) state_d = S_IDLE;
			end
			S_STAT: begin
				if (div_res.done && out_free) state_d = S_IDLE;
			end
			S_SCAN: begin
				if (scan_done) begin
					if (!range_empty) begin
						state_d = S_PICK;
					end else if (out_free) begin
						state_d = S_IDLE;
					end
				end
			end
			S_PICK: state_d = S_EMIT;
			S_EMIT: begin
				if (out_free) state_d = emit_last_q ? S_IDLE : S_PICK;
			end
			default: state_d = S_IDLE;
		endcase
	end

	// ---------------------------------------------------------------
	// Sequencer: actions
	// ---------------------------------------------------------------
	logic              push_do;
	logic              lk_start;
	logic              rg_start;
	logic              div_start;
	logic              scan_step;
	logic              pick_do;
	logic              rd_en;
	logic [IDX_W-1:0]  rd_addr;
	logic              out_load;
	status_t           o_status;
	logic [KIND_W-1:0] o_kind;
	logic [VER_W-1:0]  o_version;
	logic [SEQ_W-1:0]  o_sequence;
	logic              o_last;
	logic [SEQ_W-1:0]  o_total;
	logic [PCT_W-1:0]  o_usage;

	always_comb begin
		push_do    = 1'b0;
		lk_start   = 1'b0;
		rg_start   = 1'b0;
		div_start  = 1'b0;
		scan_step  = 1'b0;
		pick_do    = 1'b0;
		rd_en      = 1'b0;
		rd_addr    = '0;
		out_load   = 1'b0;
		o_status   = ST_OK;
		o_kind     = '0;
		o_version  = '0;
		o_sequence = '0;
		o_last     = 1'b1;
		o_total    = '0;
		o_usage    = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (req_type)
						REQ_PUSH: begin
							out_load = 1'b1;
							if (en_q) begin
								push_do    = 1'b1;
								o_kind     = event_kind;
								o_version  = obj_version;
								o_sequence = total_q;
							end else begin
								o_status = ST_REJECTED;
							end
						end
						REQ_LOOKUP: begin
							lk_start = 1'b1;
							rd_en    = 1'b1;
							rd_addr  = ring_wrap(oldest_q, lk_diff[CNT_W-1:0], cap_eff);
						end
						REQ_RANGE: rg_start  = 1'b1;
						REQ_STATS: div_start = 1'b1;
					endcase
				end
			end
			S_LOOK: begin
				if (out_free) begin
					out_load = 1'b1;
					if (hit_q) begin
						o_kind     = rd_s1[ENT_W-1:VER_W];
						o_version  = rd_s1[VER_W-1:0];
						o_sequence = query_q;
					end else begin
						o_status = ST_NOTFOUND;
					end
				end
			end
			S_STAT: begin
				if (div_res.done && out_free) begin
					out_load = 1'b1;
					o_total  = total_q;
					o_usage  = div_res.quotient;
				end
			end
			S_SCAN: begin
				if (!scan_done) begin
					scan_step = 1'b1;
				end else if (range_empty && out_free) begin
					out_load = 1'b1;
					o_status = ST_EMPTY;
				end
			end
			S_PICK: begin
				pick_do = 1'b1;
				rd_en   = 1'b1;
				rd_addr = ring_wrap(oldest_q, CNT_W'(pick_j), cap_eff);
			end
			S_EMIT: begin
				if (out_free) begin
					out_load   = 1'b1;
					o_kind     = rd_s1[ENT_W-1:VER_W];
					o_version  = rd_s1[VER_W-1:0];
					o_sequence = emit_seq_q;
					o_last     = emit_last_q;
				end
			end
			default: ;
		endcase
	end

	// usage divider
	sor_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (DIVD_W'(fill_q * PCT_SCALE)),
		.divisor  (cap_eff),
		.res      (div_res)
	);

	// ---------------------------------------------------------------
	// Control registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cap_q       <= CAP_W'(16);
			en_q        <= 1'b1;
			fill_q      <= '0;
			oldest_q    <= '0;
			next_q      <= '0;
			total_q     <= '0;
			base_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end

			if (cfg_we) begin
				unique case (cfg_index)
					CFG_CAPACITY: begin
						// capacity change empties the ring, sequences carry on
						cap_q    <= cfg_wdata[CAP_W-1:0];
						fill_q   <= '0;
						oldest_q <= '0;
						next_q   <= '0;
						base_q   <= total_q;
					end
					CFG_ENABLE: en_q <= cfg_wdata[0];
				endcase
			end else if (push_do) begin
				total_q <= total_q + SEQ_W'(1);
				next_q  <= ring_wrap(next_q, CNT_W'(1), cap_eff);
				if (fill_q >= cap_eff) begin
					// full: oldest entry is overwritten
					oldest_q <= ring_wrap(oldest_q, CNT_W'(1), cap_eff);
					base_q   <= base_q + SEQ_W'(1);
				end else begin
					fill_q <= fill_q + CNT_W'(1);
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// Working and payload registers
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (lk_start) begin
			query_q <= seq_query;
			hit_q   <= lk_hit;
		end

		if (rg_start) begin
			query_q    <= seq_query;
			maxc_q     <= max_count;
			scan_q     <= '0;
			run_seq_q  <= base_q;
			mask_q     <= '0;
			emit_cnt_q <= '0;
		end else if (scan_step) begin
			// plain unsigned compare, so a wrapped run may qualify in pieces
			mask_q[scan_q[IDX_W-1:0]] <= run_seq_q >= query_q;
			run_seq_q <= run_seq_q + SEQ_W'(1);
			scan_q    <= scan_q + CNT_W'(1);
		end else if (pick_do) begin
			mask_q[pick_j] <= 1'b0;
			emit_cnt_q     <= emit_cnt_q + CNT_W'(1);
			emit_seq_q     <= base_q + SEQ_W'(pick_j);
			emit_last_q    <= pick_last;
		end

		if (out_load) begin
			status_q    <= o_status;
			kind_q      <= o_kind;
			version_q   <= o_version;
			sequence_q  <= o_sequence;
			last_q      <= o_last;
			total_out_q <= o_total;
			usage_q     <= o_usage;
		end
	end

	// ring memory; one request at a time, so a read never meets a write
	always_ff @(posedge clk) begin
		if (push_do) begin
			ring_mem[next_q] <= {event_kind, obj_version};
		end
		if (rd_en) begin
			rd_s1 <= ring_mem[rd_addr];
		end
	end

	assign out_valid     = out_valid_q;
	assign status        = status_q;
	assign out_kind      = kind_q;
	assign out_version   = version_q;
	assign out_sequence  = sequence_q;
	assign last_of_run   = last_q;
	assign total_pushed  = total_out_q;
	assign usage_percent = usage_q;

	// ---------------------------------------------------------------
	// Assertions
	// ---------------------------------------------------------------
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= cap_eff)
		else $error("fill count above capacity");

	a_ptr_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		next_q == ring_wrap(oldest_q, fill_q, cap_eff))
		else $error("write pointer out of step with oldest and fill");

	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != S_IDLE) || out_valid_q)
		else $error("accepted transaction left no work and no result");

	a_emit_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (MAXC_W'(emit_cnt_q) <= maxc_q))
		else $error("range read emitted more than max_count");

endmodule

`default_nettype wire

// ----- verif/sequenced_overwrite_event_ring_core_tb.sv -----
module sequenced_overwrite_event_ring_core_tb
	import sor_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	// Safety net well above the slowest legal run. That run is every range
	// read emitting 16 entries, each one held by a long receiver stall.
	localparam int LIMIT_CYCLES    = 800_000;
	localparam int PHASES          = 10;
	localparam int ITEMS_PER_PHASE = 43;
	localparam int SETTLE_CYCLES   = 40;

	// one result transaction as seen on the result channel
	typedef struct packed {
		status_t          st;
		logic [KIND_W-1:0] kind;
		logic [VER_W-1:0]  ver;
		logic [SEQ_W-1:0]  seq;
		logic              last;
		logic [SEQ_W-1:0]  tot;
		logic [PCT_W-1:0]  pct;
	} reply_t;

	// directed stimulus row: either a register write or a request,
	// optionally with the reply typed in by hand
	typedef struct {
		bit                is_cfg;
		cfg_reg_t          reg_sel;
		logic [CFG_DATA_W-1:0] wdata;
		req_t              req;
		logic [KIND_W-1:0] kind;
		logic [VER_W-1:0]  ver;
		logic [SEQ_W-1:0]  query;
		logic [MAXC_W-1:0] maxc;
		bit                typed;
		reply_t            want;
	} dir_row_t;

	localparam logic [62:0] SEQ_MAX = {63{1'b1}};

	logic clk;
	logic arst_n;

	logic                  in_valid;
	logic                  in_stall;
	req_t                  req_type;
	logic [KIND_W-1:0]     event_kind;
	logic [VER_W-1:0]      obj_version;
	logic [SEQ_W-1:0]      seq_query;
	logic [MAXC_W-1:0]     max_count;

	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STAT_W-1:0]     status;
	logic [KIND_W-1:0]     out_kind;
	logic [VER_W-1:0]      out_version;
	logic [SEQ_W-1:0]      out_sequence;
	logic                  last_of_run;
	logic [SEQ_W-1:0]      total_pushed;
	logic [PCT_W-1:0]      usage_percent;

	logic                  cfg_we;
	cfg_reg_t              cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	// hand-typed reply that travels with the request currently offered
	bit     typed_pending;
	reply_t typed_reply;

	sequenced_overwrite_event_ring_core uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.in_valid         (in_valid),
		.in_stall         (in_stall),
		.req_type         (req_type),
		.event_kind       (event_kind),
		.obj_version      (obj_version),
		.seq_query        (seq_query),
		.max_count        (max_count),
		.out_valid        (out_valid),
		.out_stall        (out_stall),
		.status           (status),
		.out_kind         (out_kind),
		.out_version      (out_version),
		.out_sequence     (out_sequence),
		.last_of_run      (last_of_run),
		.total_pushed     (total_pushed),
		.usage_percent    (usage_percent),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// Ring predictor: own copy of the ring, its pointers and registers,
	// starting from the state after reset
	// ------------------------------------------------------------------
	logic [KIND_W-1:0] ring_kind [RING_DEPTH];
	logic [VER_W-1:0]  ring_ver  [RING_DEPTH];
	int                m_oldest = 0;
	int                m_next   = 0;
	int                m_fill   = 0;
	logic [SEQ_W-1:0]  m_total  = '0;
	logic [CAP_W-1:0]  m_cap    = 5'd16;
	logic              m_enable = 1'b1;

	reply_t step_replies[$];      // replies of the request just accepted
	reply_t ring_replies_due[$];  // replies still to arrive, oldest first
	int     mismatches;
	int     cycle_count;
	int     burst_left;

	function automatic void compute_ring_replies(req_t req, logic [KIND_W-1:0] kind,
			logic [VER_W-1:0] ver, logic [SEQ_W-1:0] query, logic [MAXC_W-1:0] limit);
		int cap;
		int slot;
		int n;
		logic [SEQ_W-1:0] base;
		logic [SEQ_W-1:0] seq;
		reply_t r;
		// capacity 0 behaves as 1, anything past the ring depth as the depth
		cap = (m_cap == 0) ? 1 : ((int'(m_cap) > RING_DEPTH) ? RING_DEPTH : int'(m_cap));
		// stored entries hold consecutive sequences ending at total - 1
		base = m_total - SEQ_W'(m_fill);
		step_replies.delete();
		r = '0;
		r.last = 1'b1;
		case (req)
			REQ_PUSH: begin
				if (!m_enable) begin
					r.st = ST_REJECTED;
				end else begin
					r.st   = ST_OK;
					r.seq  = m_total;
					r.kind = kind;
					r.ver  = ver;
					m_total = m_total + 1'b1;
					if (m_fill >= cap) m_oldest = (m_oldest + 1) % cap;
					else m_fill++;
					if (m_next >= cap) m_next = 0;
					ring_kind[m_next] = kind;
					ring_ver[m_next]  = ver;
					m_next = (m_next + 1) % cap;
				end
				step_replies.push_back(r);
			end
			REQ_LOOKUP: begin
				r.st = ST_NOTFOUND;
				for (int i = 0; i < m_fill; i++) begin
					seq = base + SEQ_W'(i);
					if (seq == query && r.st == ST_NOTFOUND) begin
						slot   = (m_oldest + i) % cap;
						r.st   = ST_OK;
						r.kind = ring_kind[slot];
						r.ver  = ring_ver[slot];
						r.seq  = seq;
					end
				end
				step_replies.push_back(r);
			end
			REQ_RANGE: begin
				n = 0;
				for (int i = 0; i < m_fill && n < int'(limit); i++) begin
					seq = base + SEQ_W'(i);
					if (seq >= query) begin
						slot   = (m_oldest + i) % cap;
						r      = '0;
						r.st   = ST_OK;
						r.kind = ring_kind[slot];
						r.ver  = ring_ver[slot];
						r.seq  = seq;
						step_replies.push_back(r);
						n++;
					end
				end
				if (n == 0) begin
					r    = '0;
					r.st = ST_EMPTY;
					r.last = 1'b1;
					step_replies.push_back(r);
				end else begin
					step_replies[n-1].last = 1'b1;
				end
			end
			default: begin
				r.st  = ST_OK;
				r.tot = m_total;
				r.pct = PCT_W'((m_fill * PCT_SCALE) / cap);
				step_replies.push_back(r);
			end
		endcase
	endfunction

	function automatic void check_field(string name, logic [62:0] want, logic [62:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// Single sampling process: register writes and accepted requests feed the
	// predictor, accepted results are checked against the oldest reply due.
	always @(posedge clk) begin
		reply_t want;
		if (arst_n) begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_CAPACITY: begin
						// writing the capacity empties the ring, total is kept
						m_cap    = cfg_wdata;
						m_fill   = 0;
						m_oldest = 0;
						m_next   = 0;
					end
					default: m_enable = cfg_wdata[0];
				endcase
			end
			if (in_valid && !in_stall) begin
				compute_ring_replies(req_type, event_kind, obj_version, seq_query,
						max_count);
				if (typed_pending) ring_replies_due.push_back(typed_reply);
				else foreach (step_replies[i]) ring_replies_due.push_back(step_replies[i]);
			end
			if (out_valid && !out_stall) begin
				if (ring_replies_due.size() == 0) begin
					$display("%0t: stray result, expected none, got seq %0h status %0d",
							$time, out_sequence, status);
					mismatches++;
				end else begin
					want = ring_replies_due.pop_front();
					check_field("status",        63'(want.st),   63'(status));
					check_field("out_kind",      63'(want.kind), 63'(out_kind));
					check_field("out_version",   want.ver,       out_version);
					check_field("out_sequence",  want.seq,       out_sequence);
					check_field("last_of_run",   63'(want.last), 63'(last_of_run));
					check_field("total_pushed",  want.tot,       total_pushed);
					check_field("usage_percent", 63'(want.pct),  63'(usage_percent));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > LIMIT_CYCLES) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Receiver: stall pattern switches between free flow, random stalls and long stall runs.
	// ------------------------------------------------------------------
	int stall_mode;
	int stall_left;

	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_mode <= $urandom_range(2, 0);
			stall_left <= $urandom_range(150, 40);
		end else begin
			stall_left <= stall_left - 1;
		end
		case (stall_mode)
			0:       out_stall <= 1'b0;
			1:       out_stall <= ($urandom_range(99, 0) < 35);
			default: out_stall <= (stall_left[3:0] < 4'd11);
		endcase
	end

	// ------------------------------------------------------------------
	// Sender side
	// ------------------------------------------------------------------

	// Offer one request and hold it until it is accepted. Caller has
	// already moved to a falling edge.
	task automatic drive_request(req_t req, logic [KIND_W-1:0] kind, logic [VER_W-1:0] ver,
			logic [SEQ_W-1:0] query, logic [MAXC_W-1:0] maxc, bit typed, reply_t want);
		in_valid         <= 1'b1;
		req_type         <= req;
		event_kind       <= kind;
		obj_version      <= ver;
		seq_query        <= query;
		max_count        <= maxc;
		typed_pending    <= typed;
		typed_reply      <= want;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// bursts of random length, sometimes back to back, sometimes with gaps
	task automatic sender_pause();
		int gap;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(12, 1);
			gap = ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(9, 1);
			repeat (gap) begin
				@(negedge clk);
				in_valid <= 1'b0;
			end
		end
	endtask

	// Register writes only with the ring idle: stop offering, let every
	// reply drain, then let the block settle before the write.
	task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		in_valid <= 1'b0;
		while (ring_replies_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_wdata <= data;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random request biased toward sequences the ring actually holds, with
	// a share of random queries and out-of-range counts as noise.
	task automatic drive_random_request();
		req_t req;
		logic [KIND_W-1:0] kind;
		logic [VER_W-1:0]  ver;
		logic [SEQ_W-1:0]  query;
		logic [SEQ_W-1:0]  base;
		logic [MAXC_W-1:0] maxc;
		int pick;
		pick = $urandom_range(99, 0);
		req  = (pick < 45) ? REQ_PUSH : (pick < 70) ? REQ_LOOKUP :
				(pick < 88) ? REQ_RANGE : REQ_STATS;
		kind = KIND_W'($urandom_range(7, 0));
		ver  = VER_W'({$urandom, $urandom});
		base = m_total - SEQ_W'(m_fill);
		pick = $urandom_range(9, 0);
		if (pick < 6) query = base + SEQ_W'($urandom_range(m_fill, 0));
		else if (pick < 8) query = base - SEQ_W'($urandom_range(3, 1));
		else query = SEQ_W'({$urandom, $urandom});
		pick = $urandom_range(9, 0);
		maxc = (pick < 7) ? MAXC_W'($urandom_range(16, 0)) :
				(pick < 9) ? MAXC_W'($urandom_range(64, 17)) :
				MAXC_W'($urandom_range(127, 65));
		drive_request(req, kind, ver, query, maxc, 1'b0, '0);
	endtask

	function automatic dir_row_t req_row(req_t req, logic [KIND_W-1:0] kind,
			logic [VER_W-1:0] ver, logic [SEQ_W-1:0] query, logic [MAXC_W-1:0] maxc);
		dir_row_t row;
		row         = '{default: '0, reg_sel: CFG_CAPACITY, req: REQ_PUSH, want: '0};
		row.req     = req;
		row.kind    = kind;
		row.ver     = ver;
		row.query   = query;
		row.maxc    = maxc;
		return row;
	endfunction

	function automatic dir_row_t cfg_row(cfg_reg_t sel, logic [CFG_DATA_W-1:0] data);
		dir_row_t row;
		row         = req_row(REQ_PUSH, '0, '0, '0, '0);
		row.is_cfg  = 1'b1;
		row.reg_sel = sel;
		row.wdata   = data;
		return row;
	endfunction

	// attach a single hand-typed reply (always the last of its request)
	function automatic dir_row_t with_reply(dir_row_t row, status_t st,
			logic [KIND_W-1:0] kind, logic [VER_W-1:0] ver, logic [SEQ_W-1:0] seq,
			logic [SEQ_W-1:0] tot, logic [PCT_W-1:0] pct);
		row.typed = 1'b1;
		row.want  = '{st: st, kind: kind, ver: ver, seq: seq, last: 1'b1, tot: tot, pct: pct};
		return row;
	endfunction

	dir_row_t dir_rows[$];

	initial begin
		logic [CFG_DATA_W-1:0] cap_val;
		logic [CFG_DATA_W-1:0] en_val;
		int pick;

		// known values on every input from time zero
		arst_n           = 1'b0;
		in_valid         = 1'b0;
		req_type         = REQ_PUSH;
		event_kind       = '0;
		obj_version      = '0;
		seq_query        = '0;
		max_count        = '0;
		cfg_we           = 1'b0;
		cfg_index        = CFG_CAPACITY;
		cfg_wdata        = '0;
		typed_pending    = 1'b0;
		typed_reply      = '0;
		burst_left       = 0;

		// Directed part. Empty ring first, then extremes of kind, version and
		// query, disabled pushes, overwrite at small capacity, and capacity
		// values outside the legal range (0 and above the ring depth).
		dir_rows.push_back(with_reply(req_row(REQ_STATS, 0, 0, 0, 0), ST_OK, 0, 0, 0, 0, 0));
		dir_rows.push_back(with_reply(req_row(REQ_LOOKUP, 0, 0, 0, 0), ST_NOTFOUND, 0, 0, 0, 0, 0));
		dir_rows.push_back(with_reply(req_row(REQ_RANGE, 0, 0, 0, 64), ST_EMPTY, 0, 0, 0, 0, 0));
		dir_rows.push_back(with_reply(req_row(REQ_PUSH, 0, 0, 0, 0), ST_OK, 0, 0, 0, 0, 0));
		dir_rows.push_back(with_reply(req_row(REQ_PUSH, 4, SEQ_MAX, SEQ_MAX, 127),
				ST_OK, 4, SEQ_MAX, 1, 0, 0));
		// kinds 5..7 are stored as given
		dir_rows.push_back(with_reply(req_row(REQ_PUSH, 7, 63'h2AAA_AAAA_AAAA_AAAA, 0, 0),
				ST_OK, 7, 63'h2AAA_AAAA_AAAA_AAAA, 2, 0, 0));
		dir_rows.push_back(req_row(REQ_LOOKUP, 0, 0, 1, 0));
		dir_rows.push_back(with_reply(req_row(REQ_LOOKUP, 7, SEQ_MAX, SEQ_MAX, 127),
				ST_NOTFOUND, 0, 0, 0, 0, 0));
		// zero count gives the empty-range reply even with entries stored
		dir_rows.push_back(with_reply(req_row(REQ_RANGE, 0, 0, 0, 0), ST_EMPTY, 0, 0, 0, 0, 0));
		dir_rows.push_back(req_row(REQ_RANGE, 0, 0, 0, 127));
		dir_rows.push_back(req_row(REQ_RANGE, 0, 0, 1, 1));
		dir_rows.push_back(with_reply(req_row(REQ_RANGE, 0, 0, SEQ_MAX, 64),
				ST_EMPTY, 0, 0, 0, 0, 0));
		dir_rows.push_back(with_reply(req_row(REQ_STATS, 0, 0, 0, 0), ST_OK, 0, 0, 0, 3, 18));
		dir_rows.push_back(cfg_row(CFG_ENABLE, 5'd0));
		dir_rows.push_back(with_reply(req_row(REQ_PUSH, 2, 63'd5, 0, 0), ST_REJECTED, 0, 0, 0, 0, 0));
		dir_rows.push_back(req_row(REQ_STATS, 0, 0, 0, 0));
		// only bit 0 of the enable write matters
		dir_rows.push_back(cfg_row(CFG_ENABLE, 5'b11111));
		dir_rows.push_back(cfg_row(CFG_CAPACITY, 5'd2));
		dir_rows.push_back(req_row(REQ_PUSH, 1, 63'h1234_5678_9ABC_DEF0, 0, 0));
		dir_rows.push_back(req_row(REQ_PUSH, 2, 63'h5A5A_5A5A_0F0F_0F0F, 0, 0));
		dir_rows.push_back(req_row(REQ_PUSH, 3, 63'h0000_0000_FFFF_FFFF, 0, 0));
		dir_rows.push_back(req_row(REQ_LOOKUP, 0, 0, 3, 0));
		dir_rows.push_back(req_row(REQ_RANGE, 0, 0, 0, 64));
		dir_rows.push_back(req_row(REQ_STATS, 0, 0, 0, 0));
		dir_rows.push_back(cfg_row(CFG_CAPACITY, 5'd0));
		dir_rows.push_back(req_row(REQ_PUSH, 5, SEQ_MAX, 0, 0));
		dir_rows.push_back(req_row(REQ_PUSH, 6, 0, 0, 0));
		dir_rows.push_back(req_row(REQ_LOOKUP, 0, 0, 7, 0));
		dir_rows.push_back(req_row(REQ_STATS, 0, 0, 0, 0));
		dir_rows.push_back(cfg_row(CFG_CAPACITY, 5'd31));
		dir_rows.push_back(req_row(REQ_STATS, 0, 0, 0, 0));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		foreach (dir_rows[i]) begin
			if (dir_rows[i].is_cfg) begin
				write_reg(dir_rows[i].reg_sel, dir_rows[i].wdata);
			end else begin
				@(negedge clk);
				drive_request(dir_rows[i].req, dir_rows[i].kind, dir_rows[i].ver,
						dir_rows[i].query, dir_rows[i].maxc, dir_rows[i].typed,
						dir_rows[i].want);
				sender_pause();
			end
		end

		// Random phases, each under its own register setting. The first few
		// pin the extremes; the rest draw the capacity from 0 and 2..31.
		for (int p = 0; p < PHASES; p++) begin
			pick = $urandom_range(5, 0);
			case (p)
				0: begin cap_val = 5'd16; en_val = 5'd1; end
				1: begin cap_val = 5'd1;  en_val = 5'd1; end
				2: begin cap_val = 5'd31; en_val = 5'd1; end
				3: begin cap_val = 5'd8;  en_val = 5'b11110; end
				default: begin
					cap_val = (pick == 0) ? 5'd0 : (pick == 1) ? 5'd2 :
							(pick == 2) ? 5'd16 : (pick == 3) ? 5'($urandom_range(31, 17)) :
							5'($urandom_range(15, 3));
					en_val  = {4'($urandom), 1'($urandom_range(5, 0) != 0)};
				end
			endcase
			write_reg(CFG_CAPACITY, cap_val);
			write_reg(CFG_ENABLE, en_val);
			for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
				@(negedge clk);
				drive_random_request();
				sender_pause();
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;
		while (ring_replies_due.size() != 0) @(posedge clk);
		// catch any stray results past the last expected one
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (mismatches == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
